### hdl/assert_macros.svh
// assertion macros used by the lfu_cache_table_unit rtl file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property checked on the rising clock, off during reset
`define ASSERT_AT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/lfuct_pkg.sv
// shared sizes, opcodes and cell interface types of the lfu cache table
// no dependencies
package lfuct_pkg;

    localparam int ENTRIES = 16;
    localparam int KEY_W   = 32;
    localparam int VAL_W   = 32;
    localparam int CNT_W   = 32;
    localparam int CAP_W   = 5;
    localparam int RANK_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int IDX_W   = RANK_W;
    localparam int OCC_W   = $clog2(ENTRIES + 1);
    localparam int CMP_W   = (OCC_W > CAP_W) ? OCC_W : CAP_W;
    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    // command broadcast to every cell
    typedef struct packed {
        logic              upd;
        logic              new_entry;
        logic              set_val;
        logic              thr_all;
        logic [RANK_W-1:0] thr_rank;
        logic [KEY_W-1:0]  key;
        logic [VAL_W-1:0]  val;
    } cell_cmd_t;

    // running victim candidate passed along the row
    typedef struct packed {
        logic              found;
        logic [CNT_W-1:0]  cnt;
        logic [RANK_W-1:0] rank;
        logic [IDX_W-1:0]  idx;
    } best_t;

endpackage

### hdl/lfu_cache_table_unit.sv
// lfu cache table: a row of slot cells, a victim search chain and a sequencer
// A key/value cache of ENTRIES slots with least-frequently-used replacement,
// the least recently used entry losing among equal use counts. An input beat
// carries op in s_tuser (0 get, 1 put) and key and value in s_tdata; every
// input beat gives exactly one output beat. Gets, puts to a present key and
// puts that fill a free slot go through accept, parallel key compare and
// update, then output load. A put of a new key into a full table first waits
// while the victim candidate ripples one cell per cycle down the search chain.
// One item is in flight at a time; a finished result waits in the output
// register while the next beat is taken. cap_in_use is to be written through
// cfg_we/cfg_wdata only while the block is idle; the block does not enforce
// this. Values above ENTRIES act as ENTRIES, zero turns puts into no-ops.
// depends on lfuct_pkg, lfuct_cell and assert_macros.svh
`include "assert_macros.svh"

module lfu_cache_table_unit
    import lfuct_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // configuration: cap_in_use
    input  logic                   cfg_we,
    input  logic [CAP_W-1:0]       cfg_wdata,
    // input beat
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [KEY_W+VAL_W-1:0] s_tdata,   // lookup_key, put_value
    input  logic                   s_tuser,   // op
    // output beat
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [VAL_W+KEY_W-1:0] m_tdata,   // read_value, evicted_key
    output logic [1:0]             m_tuser    // hit, evicted
);

    typedef enum logic [1:0] {ST_IDLE, ST_LOOK, ST_SCAN, ST_OUT} state_t;

    state_t             state_reg;
    logic [CAP_W-1:0]   cap_reg;
    logic [OCC_W-1:0]   occ_reg;
    logic [IDX_W-1:0]   scan_reg;
    logic               op_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [VAL_W-1:0]   val_reg;
    logic               res_hit_reg;
    logic [VAL_W-1:0]   res_rd_reg;
    logic               res_ev_reg;
    logic [KEY_W-1:0]   res_evk_reg;
    logic               m_tvalid_reg;
    logic [VAL_W+KEY_W-1:0] m_tdata_reg;
    logic [1:0]         m_tuser_reg;

    // cell row
    logic [ENTRIES-1:0] valid_vec;
    logic [KEY_W-1:0]   key_arr  [ENTRIES];
    logic [VAL_W-1:0]   val_arr  [ENTRIES];
    logic [RANK_W-1:0]  rank_arr [ENTRIES];
    best_t              best_arr [ENTRIES];
    best_t              best_none;
    cell_cmd_t          cmd;
    logic [ENTRIES-1:0] sel_vec;

    // lookup results
    logic [ENTRIES-1:0] hit_vec;
    logic               hit_any;
    logic [VAL_W-1:0]   hit_val;
    logic [RANK_W-1:0]  hit_rank;
    logic [ENTRIES-1:0] free_vec;
    logic [ENTRIES-1:0] free_oh;
    logic [ENTRIES-1:0] victim_oh;
    logic [KEY_W-1:0]   victim_key;
    logic [CMP_W-1:0]   cap_w;
    logic [CMP_W-1:0]   cap_eff;
    logic               cap_nz;
    logic               occ_full;
    logic               scan_last;
    logic               out_load;
    best_t              best_last;

    assign best_none = '0;

    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        lfuct_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .idx      (IDX_W'(i)),
            .cmd      (cmd),
            .sel      (sel_vec[i]),
            .best_in  ((i == 0) ? best_none : best_arr[(i == 0) ? 0 : i - 1]),
            .best_out (best_arr[i]),
            .valid    (valid_vec[i]),
            .key      (key_arr[i]),
            .value    (val_arr[i]),
            .rank     (rank_arr[i])
        );
        assign hit_vec[i] = valid_vec[i] && (key_arr[i] == key_reg);
    end

    // pick out the hit slot's value and rank, and the victim's key
    always_comb
    begin
        hit_val    = '0;
        hit_rank   = '0;
        victim_key = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (hit_vec[i])
            begin
                hit_val  = hit_val | val_arr[i];
                hit_rank = hit_rank | rank_arr[i];
            end
            if (victim_oh[i])
                victim_key = victim_key | key_arr[i];
        end
    end

    assign hit_any   = |hit_vec;
    assign free_vec  = ~valid_vec;
    // lowest free slot
    assign free_oh   = free_vec & (~free_vec + 1'b1);
    assign best_last = best_arr[ENTRIES-1];
    assign victim_oh = ENTRIES'(1) << best_last.idx;

    // capacity clamp and full check
    assign cap_w     = CMP_W'(cap_reg);
    assign cap_eff   = (cap_w > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES) : cap_w;
    assign cap_nz    = (cap_eff != '0);
    assign occ_full  = (CMP_W'(occ_reg) >= cap_eff);
    assign scan_last = (scan_reg == IDX_W'(ENTRIES - 1));

    // output register takes the result when empty or being drained
    assign out_load  = (state_reg == ST_OUT) && (!m_tvalid_reg || m_tready);

    // cell commands: touch on hit, fill a free slot, or evict and refill
    always_comb
    begin
        cmd          = '0;
        cmd.key      = key_reg;
        cmd.val      = val_reg;
        sel_vec      = '0;
        case (state_reg)
            ST_LOOK:
            begin
                if (hit_any && (op_reg == OP_GET || cap_nz))
                begin
                    cmd.upd      = 1'b1;
                    cmd.thr_rank = hit_rank;
                    cmd.set_val  = (op_reg == OP_PUT);
                    sel_vec      = hit_vec;
                end
                else if (op_reg == OP_PUT && cap_nz && !hit_any && !occ_full)
                begin
                    cmd.upd       = 1'b1;
                    cmd.new_entry = 1'b1;
                    cmd.thr_all   = 1'b1;
                    sel_vec       = free_oh;
                end
            end
            ST_SCAN:
            begin
                // ranks above the victim stay, the rest age by one
                if (scan_last)
                begin
                    cmd.upd       = 1'b1;
                    cmd.new_entry = 1'b1;
                    cmd.thr_rank  = best_last.rank;
                    sel_vec       = victim_oh;
                end
            end
            default:
            begin
                cmd.upd = 1'b0;
            end
        endcase
    end

    // sequencer and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cap_reg      <= CAP_RESET;
            occ_reg      <= '0;
            scan_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                cap_reg <= cfg_wdata;
            if (out_load)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        op_reg    <= s_tuser;
                        key_reg   <= s_tdata[KEY_W-1:0];
                        val_reg   <= s_tdata[KEY_W+VAL_W-1:KEY_W];
                        state_reg <= ST_LOOK;
                    end
                end
                ST_LOOK:
                begin
                    res_hit_reg <= hit_any;
                    res_rd_reg  <= (op_reg == OP_GET && hit_any) ? hit_val : '1;
                    res_ev_reg  <= 1'b0;
                    res_evk_reg <= '0;
                    scan_reg    <= '0;
                    if (op_reg == OP_PUT && cap_nz && !hit_any)
                    begin
                        if (occ_full)
                            state_reg <= ST_SCAN;
                        else
                        begin
                            occ_reg   <= occ_reg + 1'b1;
                            state_reg <= ST_OUT;
                        end
                    end
                    else
                        state_reg <= ST_OUT;
                end
                ST_SCAN:
                begin
                    // wait for the candidate to reach the end of the chain
                    scan_reg <= scan_reg + 1'b1;
                    if (scan_last)
                    begin
                        res_ev_reg  <= 1'b1;
                        res_evk_reg <= victim_key;
                        state_reg   <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    if (out_load)
                    begin
                        m_tdata_reg  <= {res_evk_reg, res_rd_reg};
                        m_tuser_reg  <= {res_ev_reg, res_hit_reg};
                        state_reg    <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // a key lives in at most one slot
    `ASSERT_AT(a_hit_onehot0, clk, rst_n, $onehot0(hit_vec), "key present in two slots")
    // fill count tracks the valid bits
    `ASSERT_AT(a_occ_match, clk, rst_n, occ_reg == $countones(valid_vec), "fill count off")
    // an eviction always finds a candidate
    `ASSERT_IMPL(a_victim_found, clk, rst_n, state_reg == ST_SCAN && scan_last,
                 best_last.found, "no victim at end of scan")

endmodule

### hdl/lfuct_cell.sv
// one slot of the cache table plus one stage of the victim search chain
// depends on lfuct_pkg
module lfuct_cell
    import lfuct_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [IDX_W-1:0]  idx,
    input  cell_cmd_t         cmd,
    input  logic              sel,
    input  best_t             best_in,
    output best_t             best_out,
    output logic              valid,
    output logic [KEY_W-1:0]  key,
    output logic [VAL_W-1:0]  value,
    output logic [RANK_W-1:0] rank
);

    logic              valid_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [VAL_W-1:0]  value_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [RANK_W-1:0] rank_reg;
    best_t             best_reg;
    best_t             best_next;

    // lower count wins, older rank breaks ties
    always_comb
    begin
        best_next = best_in;
        if (valid_reg && (!best_in.found || cnt_reg < best_in.cnt ||
            (cnt_reg == best_in.cnt && rank_reg > best_in.rank)))
        begin
            best_next.found = 1'b1;
            best_next.cnt   = cnt_reg;
            best_next.rank  = rank_reg;
            best_next.idx   = idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= 1'b0;
            best_reg.found <= 1'b0;
        end
        else
        begin
            best_reg <= best_next;
            if (cmd.upd)
            begin
                if (sel)
                begin
                    rank_reg <= '0;
                    if (cmd.new_entry)
                    begin
                        valid_reg <= 1'b1;
                        key_reg   <= cmd.key;
                        value_reg <= cmd.val;
                        cnt_reg   <= CNT_W'(1);
                    end
                    else
                    begin
                        if (cnt_reg != '1)
                            cnt_reg <= cnt_reg + 1'b1;
                        if (cmd.set_val)
                            value_reg <= cmd.val;
                    end
                end
                else if (valid_reg && (cmd.thr_all || rank_reg < cmd.thr_rank))
                begin
                    rank_reg <= rank_reg + 1'b1;
                end
            end
        end
    end

    assign best_out = best_reg;
    assign valid    = valid_reg;
    assign key      = key_reg;
    assign value    = value_reg;
    assign rank     = rank_reg;

endmodule

### test/lfu_cache_table_unit_chk.sv
// checker for the lfu cache table: watches both streams, predicts each result
// and compares it field by field; depends on lfuct_pkg
`timescale 1ns / 1ps

module lfu_cache_table_unit_chk
    import lfuct_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CAP_W-1:0]       cfg_wdata,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [KEY_W+VAL_W-1:0] s_tdata,
    input  logic                   s_tuser,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [VAL_W+KEY_W-1:0] m_tdata,
    input  logic [1:0]             m_tuser,
    output int                     fail_count,
    output int                     pending
);

    typedef struct packed {
        logic             hit;
        logic [VAL_W-1:0] read_value;
        logic             evicted;
        logic [KEY_W-1:0] evicted_key;
    } lookup_result_t;

    logic [CAP_W-1:0]  cap_sh;
    logic              v_sh   [ENTRIES];
    logic [KEY_W-1:0]  key_sh [ENTRIES];
    logic [VAL_W-1:0]  val_sh [ENTRIES];
    logic [CNT_W-1:0]  cnt_sh [ENTRIES];
    int                age_sh [ENTRIES];

    lookup_result_t result_q[$];

    assign pending = result_q.size();

    // mark a slot most recent and bump its saturating count
    function automatic void bump_slot(int s);
        for (int i = 0; i < ENTRIES; i++)
            if (i != s && v_sh[i] && age_sh[i] < age_sh[s])
                age_sh[i]++;
        age_sh[s] = 0;
        if (cnt_sh[s] != '1)
            cnt_sh[s]++;
    endfunction

    function automatic lookup_result_t cache_access(logic op, logic [KEY_W-1:0] k,
                                                    logic [VAL_W-1:0] v);
        lookup_result_t r;
        int s;
        int cap;
        int occ;
        int dst;
        r = '{hit: 1'b0, read_value: '1, evicted: 1'b0, evicted_key: '0};
        cap = (cap_sh > ENTRIES) ? ENTRIES : int'(cap_sh);
        s = -1;
        for (int i = 0; i < ENTRIES; i++)
            if (s < 0 && v_sh[i] && key_sh[i] == k)
                s = i;
        r.hit = (s >= 0);
        if (op == OP_GET) begin
            if (s >= 0) begin
                r.read_value = val_sh[s];
                bump_slot(s);
            end
        end else if (cap != 0) begin
            if (s >= 0) begin
                val_sh[s] = v;
                bump_slot(s);
            end else begin
                occ = 0;
                dst = -1;
                for (int i = 0; i < ENTRIES; i++)
                    if (v_sh[i])
                        occ++;
                if (occ >= cap) begin
                    // lowest count, oldest among equals
                    for (int i = 0; i < ENTRIES; i++)
                        if (v_sh[i] && (dst < 0 || cnt_sh[i] < cnt_sh[dst] ||
                            (cnt_sh[i] == cnt_sh[dst] && age_sh[i] > age_sh[dst])))
                            dst = i;
                    if (dst >= 0) begin
                        r.evicted = 1'b1;
                        r.evicted_key = key_sh[dst];
                        v_sh[dst] = 1'b0;
                        for (int i = 0; i < ENTRIES; i++)
                            if (v_sh[i] && age_sh[i] > age_sh[dst])
                                age_sh[i]--;
                    end
                end else begin
                    for (int i = ENTRIES - 1; i >= 0; i--)
                        if (!v_sh[i])
                            dst = i;
                end
                if (dst >= 0) begin
                    for (int i = 0; i < ENTRIES; i++)
                        if (v_sh[i])
                            age_sh[i]++;
                    v_sh[dst] = 1'b1;
                    key_sh[dst] = k;
                    val_sh[dst] = v;
                    cnt_sh[dst] = CNT_W'(1);
                    age_sh[dst] = 0;
                end
            end
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        lookup_result_t e;
        lookup_result_t a;
        if (!rst_n) begin
            cap_sh = CAP_RESET;
            for (int i = 0; i < ENTRIES; i++) begin
                v_sh[i] = 1'b0;
                age_sh[i] = 0;
                cnt_sh[i] = '0;
            end
            result_q.delete();
            fail_count = 0;
        end else begin
            if (cfg_we)
                cap_sh = cfg_wdata;
            if (s_tvalid && s_tready)
                result_q.push_back(cache_access(s_tuser, s_tdata[KEY_W-1:0],
                                                s_tdata[KEY_W+VAL_W-1:KEY_W]));
            if (m_tvalid && m_tready) begin
                a.hit = m_tuser[0];
                a.evicted = m_tuser[1];
                a.read_value = m_tdata[VAL_W-1:0];
                a.evicted_key = m_tdata[VAL_W+KEY_W-1:VAL_W];
                if (result_q.size() == 0) begin
                    $error("result beat with nothing expected");
                    fail_count++;
                end else begin
                    e = result_q.pop_front();
                    if (a.hit !== e.hit) begin
                        $error("hit: expected %0h, got %0h", e.hit, a.hit);
                        fail_count++;
                    end
                    if (a.read_value !== e.read_value) begin
                        $error("read_value: expected %0h, got %0h", e.read_value,
                               a.read_value);
                        fail_count++;
                    end
                    if (a.evicted !== e.evicted) begin
                        $error("evicted: expected %0h, got %0h", e.evicted, a.evicted);
                        fail_count++;
                    end
                    if (a.evicted_key !== e.evicted_key) begin
                        $error("evicted_key: expected %0h, got %0h", e.evicted_key,
                               a.evicted_key);
                        fail_count++;
                    end
                end
            end
        end
    end

endmodule

### test/lfu_cache_table_unit_tb.sv
// stimulus top for the lfu cache table: clock, reset, capacity phases and
// get/put beats with random gaps; depends on lfuct_pkg and the checker module
`timescale 1ns / 1ps

module lfu_cache_table_unit_tb;
    import lfuct_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CAP_W-1:0]       cfg_wdata = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [KEY_W+VAL_W-1:0] s_tdata = '0;
    logic                   s_tuser = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [VAL_W+KEY_W-1:0] m_tdata;
    logic [1:0]             m_tuser;
    int                     fail_count;
    int                     pending;
    int                     cycles = 0;
    logic [KEY_W-1:0]       key_pool [8];

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    lfu_cache_table_unit u_dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    lfu_cache_table_unit_chk u_chk (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .fail_count(fail_count), .pending(pending)
    );

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("lfu_cache_table_unit: mismatch");
            $finish;
        end
    end

    // receiver: random stall per beat, sometimes none at all
    initial
    begin
        int w;
        forever begin
            @(negedge clk);
            w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
            if (w > 0) begin
                m_tready <= 1'b0;
                repeat (w) @(negedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!(m_tvalid && m_tready));
        end
    end

    // one beat with an optional random gap ahead of it; valid drops only in a gap
    task automatic send_beat(logic op, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v,
                             bit no_gap);
        int w;
        w = no_gap ? 0 : $urandom_range(0, 5);
        @(negedge clk);
        if (w > 0) begin
            s_tvalid <= 1'b0;
            repeat (w) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {v, k};
        do @(posedge clk); while (!s_tready);
    endtask

    // stop sending, wait for the table to go idle, then let the chain settle
    task automatic drain;
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (ENTRIES + 8) @(negedge clk);
    endtask

    task automatic set_capacity(logic [CAP_W-1:0] c);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= c;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial
    begin
        logic [CAP_W-1:0] caps [8];
        logic             op;
        logic [KEY_W-1:0] k;
        bit               burst;
        caps = '{5'd16, 5'd4, 5'd1, 5'd0, 5'd31, 5'd17, 5'd8, 5'd2};
        for (int i = 0; i < 8; i++)
            key_pool[i] = $urandom();
        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7fff_ffff;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: extremes, hits, misses, updates, eviction, zero capacity
        send_beat(OP_GET, 32'h0, 32'h0, 0);
        send_beat(OP_PUT, 32'h8000_0000, 32'h7fff_ffff, 0);
        send_beat(OP_PUT, 32'h7fff_ffff, 32'h8000_0000, 0);
        send_beat(OP_PUT, 32'hffff_ffff, 32'hffff_ffff, 0);
        send_beat(OP_GET, 32'h8000_0000, 32'h0, 0);
        send_beat(OP_PUT, 32'h7fff_ffff, 32'h1234_5678, 0);
        send_beat(OP_GET, 32'h7fff_ffff, 32'hffff_ffff, 0);
        send_beat(OP_GET, 32'h0, 32'h0, 0);
        // lowering capacity below occupancy: one eviction per new put
        set_capacity(5'd2);
        send_beat(OP_PUT, 32'h0, 32'h5555_aaaa, 0);
        send_beat(OP_PUT, 32'h1, 32'haaaa_5555, 0);
        send_beat(OP_GET, 32'hffff_ffff, 32'h0, 0);
        // zero capacity: puts ignored, hits still reported
        set_capacity(5'd0);
        send_beat(OP_PUT, 32'h1, 32'h0, 0);
        send_beat(OP_PUT, 32'h2, 32'h0, 0);
        send_beat(OP_GET, 32'h1, 32'h0, 0);

        // random phases across capacities, small key pools for reuse
        for (int ph = 0; ph < 8; ph++) begin
            set_capacity(caps[ph]);
            burst = (ph % 2 == 1);
            for (int n = 0; n < 105; n++) begin
                op = 1'($urandom_range(0, 1));
                if ($urandom_range(0, 9) < 8)
                    k = key_pool[$urandom_range(0, 7)] ^ KEY_W'($urandom_range(0, 11));
                else
                    k = $urandom();
                send_beat(op, k, $urandom(), burst && n < 40);
                if (n == 60)
                    drain();
            end
        end

        drain();
        if (fail_count == 0)
            $display("lfu_cache_table_unit: match");
        else
            $display("lfu_cache_table_unit: mismatch");
        $finish;
    end

endmodule

### sim.f
+incdir+hdl
hdl/lfuct_pkg.sv
hdl/lfuct_cell.sv
hdl/lfu_cache_table_unit.sv
test/lfu_cache_table_unit_chk.sv
test/lfu_cache_table_unit_tb.sv
